// ----- rtl/mdm_pkg.sv -----
// ----------------------------------------------------------------------------
// mdm_pkg
// Shared types and constants of the mecanum drive mixer: register indexes,
// turn mode and mode request codes, field widths and sine table constants.
// ----------------------------------------------------------------------------
package mdm_pkg;

	localparam int SPEED_W = 14;
	localparam int ANGLE_W = 16;
	localparam int WHEEL_W = 15;
	localparam int RPM_W   = 14;
	localparam int GAIN_W  = 16;
	localparam int MAP_W   = 8;
	localparam int INV_W   = 4;
	localparam int ADDR_W  = 5;
	localparam int DATA_W  = 32;
	localparam int SINE_W  = 16;

	typedef enum logic [2:0] {
		REG_MAX_RPM     = 3'd0,
		REG_ROTATE_MIN  = 3'd1,
		REG_ROTATE_MAX  = 3'd2,
		REG_ROTATE_GAIN = 3'd3,
		REG_CHANNEL_MAP = 3'd4,
		REG_INVERT_MASK = 3'd5
	} reg_idx_t;

	typedef enum logic [1:0] {
		MODE_SHORTEST = 2'd0,
		MODE_CCW      = 2'd1,
		MODE_CW       = 2'd2
	} turn_mode_t;

	typedef enum logic [1:0] {
		REQ_KEEP     = 2'd0,
		REQ_SHORTEST = 2'd1,
		REQ_CCW      = 2'd2,
		REQ_CW       = 2'd3
	} mode_req_t;

	localparam logic [RPM_W-1:0]  MAX_RPM_RST     = 14'd4000;
	localparam logic [RPM_W-1:0]  ROTATE_MIN_RST  = 14'd100;
	localparam logic [RPM_W-1:0]  ROTATE_MAX_RST  = 14'd2000;
	localparam logic [GAIN_W-1:0] ROTATE_GAIN_RST = 16'd1024;
	localparam logic [MAP_W-1:0]  CHANNEL_MAP_RST = 8'd228;
	localparam logic [INV_W-1:0]  INVERT_MASK_RST = 4'd0;

	// pi in Q30, series divisors (2k)(2k+1) for k = 1..8
	localparam logic [63:0] PI_Q30 = 64'd3373259426;
	localparam int TAYLOR_TERMS = 8;
	localparam logic [63:0] TAYLOR_DIV [TAYLOR_TERMS] = '{
		64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
	};
	localparam logic [63:0] Q15_HALF = 64'd16384;
	localparam logic [63:0] Q15_ONE  = 64'd32768;

endpackage

// ----- rtl/mdm_cmd_if.sv -----
// ----------------------------------------------------------------------------
// mdm_cmd_if
// Command channel of the mixer: speed, direction, headings and mode request.
// ----------------------------------------------------------------------------
interface mdm_cmd_if;
	logic                                valid;
	logic                                ready;
	logic        [mdm_pkg::SPEED_W-1:0]  drive_speed;
	logic signed [mdm_pkg::ANGLE_W-1:0]  drive_direction;
	logic signed [mdm_pkg::ANGLE_W-1:0]  target_heading;
	logic signed [mdm_pkg::ANGLE_W-1:0]  measured_heading;
	logic        [1:0]                   mode_request;

	modport source (
		output valid, drive_speed, drive_direction, target_heading,
		       measured_heading, mode_request,
		input  ready
	);
	modport sink (
		input  valid, drive_speed, drive_direction, target_heading,
		       measured_heading, mode_request,
		output ready
	);
endinterface

// ----- rtl/mdm_wheel_if.sv -----
// ----------------------------------------------------------------------------
// mdm_wheel_if
// Result channel of the mixer: four wheel targets, speed error and turn mode.
// ----------------------------------------------------------------------------
interface mdm_wheel_if;
	logic                                valid;
	logic                                ready;
	logic signed [mdm_pkg::WHEEL_W-1:0]  wheel_front_right;
	logic signed [mdm_pkg::WHEEL_W-1:0]  wheel_front_left;
	logic signed [mdm_pkg::WHEEL_W-1:0]  wheel_back_right;
	logic signed [mdm_pkg::WHEEL_W-1:0]  wheel_back_left;
	logic                                speed_error;
	logic        [1:0]                   active_mode;

	modport source (
		output valid, wheel_front_right, wheel_front_left, wheel_back_right,
		       wheel_back_left, speed_error, active_mode,
		input  ready
	);
	modport sink (
		input  valid, wheel_front_right, wheel_front_left, wheel_back_right,
		       wheel_back_left, speed_error, active_mode,
		output ready
	);
endinterface

// ----- rtl/mdm_front.sv -----
// ----------------------------------------------------------------------------
// mdm_front
// Takes command requests, keeps the turn mode, forms the wrapped heading error
// and the two sine table indexes, and flags speeds above max rpm.
// ----------------------------------------------------------------------------
module mdm_front #(
	parameter int ANGLE_BITS       = 16,
	parameter int SINE_TABLE_DEPTH = 256,
	parameter int ITEM_W           = 60
) (
	input  logic                         clk,
	input  logic                         arst_n,
	mdm_cmd_if.sink                      cmd,
	input  logic [mdm_pkg::RPM_W-1:0]    max_rpm,
	output logic                         push_valid,
	input  logic                         push_ready,
	output logic [ITEM_W-1:0]            push_item
);

	localparam int A        = ANGLE_BITS;
	localparam int IW       = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PW       = A - 2 + IW + 1;
	localparam int ROUND_Q  = 1 << (A - 3);
	localparam logic [A-1:0] HALF    = A'(1) << (A - 1);
	localparam logic [A-1:0] QUARTER = A'(1) << (A - 2);
	localparam logic [A-1:0] EIGHTH  = A'(1) << (A - 3);

	typedef struct packed {
		logic [mdm_pkg::SPEED_W-1:0] speed;
		logic                        spd_err;
		mdm_pkg::turn_mode_t         mode;
		logic                        err_neg;
		logic [A-1:0]                aerr;
		logic [IW-1:0]               idx1;
		logic                        neg1;
		logic [IW-1:0]               idx2;
		logic                        neg2;
	} item_t;

	function automatic logic [IW:0] sine_index(input logic [A-1:0] a);
		logic [PW-1:0] p;
		logic [IW-1:0] idx;
		p = PW'(a[A-3:0]) * PW'(SINE_TABLE_DEPTH) + PW'(ROUND_Q);
		idx = IW'(p >> (A - 2));
		if (idx > IW'(SINE_TABLE_DEPTH)) begin
			idx = IW'(SINE_TABLE_DEPTH);
		end
		if (a[A-2]) begin
			idx = IW'(SINE_TABLE_DEPTH) - idx;
		end
		return {a[A-1], idx};
	endfunction

	mdm_pkg::turn_mode_t turn_mode_q;
	mdm_pkg::turn_mode_t mode_req;
	mdm_pkg::turn_mode_t mode_next;
	logic [A-1:0]        dir;
	logic [A-1:0]        tgt;
	logic [A-1:0]        meas;
	logic [A-1:0]        diff;
	logic [A-1:0]        rel;
	logic [A-1:0]        aerr;
	logic                err_neg;
	logic                spd_err;
	logic [IW:0]         sidx1;
	logic [IW:0]         sidx2;
	logic                accept;
	item_t               item;

	assign dir  = A'($unsigned(cmd.drive_direction));
	assign tgt  = A'($unsigned(cmd.target_heading));
	assign meas = A'($unsigned(cmd.measured_heading));
	assign diff = tgt - meas;
	assign rel  = dir - meas;

	assign spd_err = cmd.drive_speed > max_rpm;

	always_comb begin
		case (mdm_pkg::mode_req_t'(cmd.mode_request))
			mdm_pkg::REQ_SHORTEST: mode_req = mdm_pkg::MODE_SHORTEST;
			mdm_pkg::REQ_CCW:      mode_req = mdm_pkg::MODE_CCW;
			mdm_pkg::REQ_CW:       mode_req = mdm_pkg::MODE_CW;
			default: begin
				if (turn_mode_q inside {mdm_pkg::MODE_CCW, mdm_pkg::MODE_CW}) begin
					mode_req = turn_mode_q;
				end else begin
					mode_req = mdm_pkg::MODE_SHORTEST;
				end
			end
		endcase
	end

	always_comb begin
		case (mode_req)
			mdm_pkg::MODE_CCW: begin
				err_neg = 1'b0;
				aerr    = diff;
			end
			mdm_pkg::MODE_CW: begin
				err_neg = diff != '0;
				aerr    = -diff;
			end
			default: begin
				err_neg = diff > HALF;
				aerr    = (diff > HALF) ? -diff : diff;
			end
		endcase
	end

	// revert to shortest once inside a quarter turn, not on a speed error
	always_comb begin
		if (!spd_err && aerr < QUARTER) begin
			mode_next = mdm_pkg::MODE_SHORTEST;
		end else begin
			mode_next = mode_req;
		end
	end

	assign sidx1 = sine_index(rel - EIGHTH);
	assign sidx2 = sine_index(rel + EIGHTH);

	always_comb begin
		item.speed   = cmd.drive_speed;
		item.spd_err = spd_err;
		item.mode    = mode_next;
		item.err_neg = err_neg;
		item.aerr    = aerr;
		item.idx1    = sidx1[IW-1:0];
		item.neg1    = sidx1[IW];
		item.idx2    = sidx2[IW-1:0];
		item.neg2    = sidx2[IW];
	end

	assign push_item  = item;
	assign push_valid = cmd.valid;
	assign cmd.ready  = push_ready;
	assign accept     = cmd.valid && push_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			turn_mode_q <= mdm_pkg::MODE_SHORTEST;
		end else if (accept) begin
			turn_mode_q <= mode_next;
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		accept && !spd_err && cmd.mode_request == mdm_pkg::REQ_CCW && aerr >= QUARTER
		|=> turn_mode_q == mdm_pkg::MODE_CCW)
		else $error("ccw request beyond a quarter turn not kept");

endmodule

// ----- rtl/mdm_queue.sv -----
// ----------------------------------------------------------------------------
// mdm_queue
// Short request queue between the front and the back of the mixer.
// ----------------------------------------------------------------------------
module mdm_queue #(
	parameter int W     = 60,
	parameter int DEPTH = 2
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         push_valid,
	output logic         push_ready,
	input  logic [W-1:0] push_item,
	output logic         pop_valid,
	input  logic         pop_ready,
	output logic [W-1:0] pop_item
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_ptr_q;
	logic [PTR_W-1:0] rd_ptr_q;
	logic [CNT_W-1:0] count_q;
	logic             push;
	logic             pop;

	assign push_ready = count_q != CNT_W'(DEPTH);
	assign pop_valid  = count_q != '0;
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(DEPTH))
		else $error("queue count beyond depth");

	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> count_q == $past(count_q) + 1'b1)
		else $error("queue count lost a push");

endmodule

// ----- rtl/mdm_back.sv -----
// ----------------------------------------------------------------------------
// mdm_back
// Carries out queued requests: sine lookup, rotate P term with clamp, wheel
// mixing, rotate trim against max rpm, channel remap and sign inversion.
// ----------------------------------------------------------------------------
module mdm_back #(
	parameter int ANGLE_BITS       = 16,
	parameter int SINE_TABLE_DEPTH = 256,
	parameter int GAIN_SHIFT       = 13,
	parameter int DEADBAND_ANGLE   = 364,
	parameter int ITEM_W           = 60
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          pop_valid,
	output logic                          pop_ready,
	input  logic [ITEM_W-1:0]             pop_item,
	input  logic [mdm_pkg::RPM_W-1:0]     max_rpm,
	input  logic [mdm_pkg::RPM_W-1:0]     rotate_min,
	input  logic [mdm_pkg::RPM_W-1:0]     rotate_max,
	input  logic [mdm_pkg::GAIN_W-1:0]    rotate_gain,
	input  logic [mdm_pkg::MAP_W-1:0]     channel_map,
	input  logic [mdm_pkg::INV_W-1:0]     invert_mask,
	mdm_wheel_if.source                   wheel
);

	localparam int A        = ANGLE_BITS;
	localparam int IW       = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int PW       = A + mdm_pkg::GAIN_W;
	localparam int DBW      = A + 13;
	localparam int SW       = mdm_pkg::SINE_W;
	localparam int VPW      = mdm_pkg::SPEED_W + SW;
	localparam int RW       = mdm_pkg::RPM_W;
	localparam int WW       = mdm_pkg::WHEEL_W;
	localparam int TWO_DEPTH = 2 * SINE_TABLE_DEPTH;

	typedef struct packed {
		logic [mdm_pkg::SPEED_W-1:0] speed;
		logic                        spd_err;
		mdm_pkg::turn_mode_t         mode;
		logic                        err_neg;
		logic [A-1:0]                aerr;
		logic [IW-1:0]               idx1;
		logic                        neg1;
		logic [IW-1:0]               idx2;
		logic                        neg2;
	} item_t;

	function automatic logic [SW-1:0] sine_entry(input int unsigned i);
		logic [63:0] x;
		logic [63:0] term;
		logic [63:0] sum;
		x = (64'(i) * mdm_pkg::PI_Q30) / 64'(TWO_DEPTH);
		term = x;
		sum = x;
		for (int k = 1; k <= mdm_pkg::TAYLOR_TERMS; k++) begin
			term = (term * x) >> 30;
			term = (term * x) >> 30;
			term = term / mdm_pkg::TAYLOR_DIV[k-1];
			if (k % 2 == 1) begin
				sum = (sum >= term) ? sum - term : 64'd0;
			end else begin
				sum = sum + term;
			end
		end
		sum = (sum + mdm_pkg::Q15_HALF) >> 15;
		if (sum > mdm_pkg::Q15_ONE) begin
			sum = mdm_pkg::Q15_ONE;
		end
		return sum[SW-1:0];
	endfunction

	// quarter-wave table, Q15
	logic [SW-1:0] sine_rom [SINE_TABLE_DEPTH + 1];

	for (genvar g = 0; g <= SINE_TABLE_DEPTH; g++) begin : g_rom
		assign sine_rom[g] = sine_entry(g);
	end

	item_t it;
	assign it = pop_item;

	// stage 1: table lookup, gain product
	logic                        vld_s1;
	logic [mdm_pkg::SPEED_W-1:0] speed_s1;
	logic                        spd_err_s1;
	mdm_pkg::turn_mode_t         mode_s1;
	logic                        err_neg_s1;
	logic                        db_s1;
	logic [PW-1:0]               prod_s1;
	logic [SW-1:0]               smag1_s1;
	logic [SW-1:0]               smag2_s1;
	logic                        neg1_s1;
	logic                        neg2_s1;

	// stage 2: speed products, clamped rotate
	logic                        vld_s2;
	logic                        spd_err_s2;
	mdm_pkg::turn_mode_t         mode_s2;
	logic [VPW-1:0]              vprod1_s2;
	logic [VPW-1:0]              vprod2_s2;
	logic                        neg1_s2;
	logic                        neg2_s2;
	logic signed [WW-1:0]        rot_s2;

	// stage 3: translation terms
	logic                        vld_s3;
	logic                        spd_err_s3;
	mdm_pkg::turn_mode_t         mode_s3;
	logic signed [WW-1:0]        v1_s3;
	logic signed [WW-1:0]        v2_s3;
	logic [RW-1:0]               big_s3;
	logic signed [WW-1:0]        rot_s3;

	logic                        out_vld_q;
	logic                        out_free;
	logic                        s3_free;
	logic                        s2_free;
	logic                        s1_free;

	assign out_free  = !out_vld_q || wheel.ready;
	assign s3_free   = !vld_s3 || out_free;
	assign s2_free   = !vld_s2 || s3_free;
	assign s1_free   = !vld_s1 || s2_free;
	assign pop_ready = s1_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1    <= 1'b0;
			vld_s2    <= 1'b0;
			vld_s3    <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (s1_free) begin
				vld_s1 <= pop_valid;
			end
			if (s2_free) begin
				vld_s2 <= vld_s1;
			end
			if (s3_free) begin
				vld_s3 <= vld_s2;
			end
			if (out_free) begin
				out_vld_q <= vld_s3;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s1_free && pop_valid) begin
			speed_s1   <= it.speed;
			spd_err_s1 <= it.spd_err;
			mode_s1    <= it.mode;
			err_neg_s1 <= it.err_neg;
			db_s1      <= DBW'(it.aerr) < DBW'(DEADBAND_ANGLE);
			prod_s1    <= PW'(it.aerr) * PW'(rotate_gain);
			smag1_s1   <= sine_rom[it.idx1];
			smag2_s1   <= sine_rom[it.idx2];
			neg1_s1    <= it.neg1;
			neg2_s1    <= it.neg2;
		end
	end

	logic [PW-1:0]        shifted;
	logic [RW-1:0]        rot_mag;
	logic signed [WW-1:0] rot_mag_s;

	always_comb begin
		shifted = prod_s1 >> GAIN_SHIFT;
		if (db_s1 || prod_s1 == '0) begin
			rot_mag = '0;
		end else if (shifted < PW'(rotate_min)) begin
			rot_mag = rotate_min;
		end else if (shifted > PW'(rotate_max)) begin
			rot_mag = rotate_max;
		end else begin
			rot_mag = shifted[RW-1:0];
		end
		rot_mag_s = $signed({1'b0, rot_mag});
	end

	always_ff @(posedge clk) begin
		if (s2_free && vld_s1) begin
			spd_err_s2 <= spd_err_s1;
			mode_s2    <= mode_s1;
			vprod1_s2  <= VPW'(speed_s1) * VPW'(smag1_s1);
			vprod2_s2  <= VPW'(speed_s1) * VPW'(smag2_s1);
			neg1_s2    <= neg1_s1;
			neg2_s2    <= neg2_s1;
			rot_s2     <= err_neg_s1 ? -rot_mag_s : rot_mag_s;
		end
	end

	logic [RW-1:0]        vm1;
	logic [RW-1:0]        vm2;
	logic signed [WW-1:0] vm1_s;
	logic signed [WW-1:0] vm2_s;

	always_comb begin
		vm1   = RW'((vprod1_s2 + VPW'(mdm_pkg::Q15_HALF)) >> 15);
		vm2   = RW'((vprod2_s2 + VPW'(mdm_pkg::Q15_HALF)) >> 15);
		vm1_s = $signed({1'b0, vm1});
		vm2_s = $signed({1'b0, vm2});
	end

	always_ff @(posedge clk) begin
		if (s3_free && vld_s2) begin
			spd_err_s3 <= spd_err_s2;
			mode_s3    <= mode_s2;
			v1_s3      <= neg1_s2 ? -vm1_s : vm1_s;
			v2_s3      <= neg2_s2 ? -vm2_s : vm2_s;
			big_s3     <= (vm1 > vm2) ? vm1 : vm2;
			rot_s3     <= rot_s2;
		end
	end

	// mix, trim rotate, remap and invert
	logic signed [WW:0]   raw [4];
	logic signed [WW:0]   mix [4];
	logic [WW:0]          amag [4];
	logic                 ovf;
	logic signed [WW-1:0] room;
	logic signed [WW-1:0] rot_t;
	logic signed [WW-1:0] wsel [4];
	logic signed [WW-1:0] wout [4];

	always_comb begin
		raw[0] = (WW+1)'(v1_s3) + (WW+1)'(rot_s3);
		raw[1] = (WW+1)'(v2_s3) - (WW+1)'(rot_s3);
		raw[2] = (WW+1)'(v2_s3) + (WW+1)'(rot_s3);
		raw[3] = (WW+1)'(v1_s3) - (WW+1)'(rot_s3);
		ovf = 1'b0;
		for (int j = 0; j < 4; j++) begin
			amag[j] = raw[j][WW] ? -raw[j] : raw[j];
			if (amag[j] > (WW+1)'(max_rpm)) begin
				ovf = 1'b1;
			end
		end
		room = $signed({1'b0, max_rpm - big_s3});
		if (!ovf) begin
			rot_t = rot_s3;
		end else if (rot_s3 < 0) begin
			rot_t = -room;
		end else if (rot_s3 > 0) begin
			rot_t = room;
		end else begin
			rot_t = '0;
		end
		mix[0] = (WW+1)'(v1_s3) + (WW+1)'(rot_t);
		mix[1] = (WW+1)'(v2_s3) - (WW+1)'(rot_t);
		mix[2] = (WW+1)'(v2_s3) + (WW+1)'(rot_t);
		mix[3] = (WW+1)'(v1_s3) - (WW+1)'(rot_t);
		for (int j = 0; j < 4; j++) begin
			wsel[j] = mix[channel_map[2*j +: 2]][WW-1:0];
			if (spd_err_s3) begin
				wout[j] = '0;
			end else if (invert_mask[j]) begin
				wout[j] = -wsel[j];
			end else begin
				wout[j] = wsel[j];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && vld_s3) begin
			wheel.wheel_front_right <= wout[0];
			wheel.wheel_front_left  <= wout[1];
			wheel.wheel_back_right  <= wout[2];
			wheel.wheel_back_left   <= wout[3];
			wheel.speed_error       <= spd_err_s3;
			wheel.active_mode       <= mode_s3;
		end
	end

	assign wheel.valid = out_vld_q;

	assert property (@(posedge clk) disable iff (!arst_n)
		wheel.valid && wheel.speed_error |->
		wheel.wheel_front_right == '0 && wheel.wheel_front_left == '0 &&
		wheel.wheel_back_right == '0 && wheel.wheel_back_left == '0)
		else $error("speed error request with nonzero wheels");

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 && !out_free |=> vld_s3 && $stable(v1_s3) && $stable(rot_s3))
		else $error("stalled mix stage changed");

	assert property (@(posedge clk) disable iff (!arst_n)
		vld_s2 && !s3_free |=> vld_s2 && $stable(rot_s2))
		else $error("stalled rotate stage changed");

endmodule

// ----- rtl/mecanum_drive_mixer_top.sv -----
// ----------------------------------------------------------------------------
// mecanum_drive_mixer_top
// Mecanum wheel mixer with proportional heading hold and APB register port.
// ----------------------------------------------------------------------------
// cmd carries one request per valid/ready transfer: drive speed, direction,
// target and measured heading and a turn mode request. wheel returns one
// result per request, in order: four wheel targets after channel remap and
// inversion, a speed error flag and the turn mode kept after the request.
// The front takes a request every cycle while the queue has room and updates
// the turn mode at once, so requests may follow back to back at one per cycle.
// A taken request enters the queue, which hands it on into table lookup with
// gain product, then speed products with rotate clamp, the rounded
// translation terms, and the mix with trim and remap into the output
// register, where its result is valid.
// When wheel is not ready the back pipeline holds, the queue fills and then
// cmd.ready drops; nothing is dropped or repeated.
// Reset clears the turn mode to shortest, empties queue and pipeline and
// loads the register defaults. Registers sit at byte address 4*i; the user
// must write them only while no request is in flight; the block does not enforce it.
// ----------------------------------------------------------------------------
module mecanum_drive_mixer_top #(
	parameter int ANGLE_BITS       = 16,
	parameter int SINE_TABLE_DEPTH = 256,
	parameter int GAIN_SHIFT       = 13,
	parameter int DEADBAND_ANGLE   = 364,
	parameter int QUEUE_DEPTH      = 2
) (
	input  logic                          clk,
	input  logic                          arst_n,
	mdm_cmd_if.sink                       cmd,
	mdm_wheel_if.source                   wheel,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [mdm_pkg::ADDR_W-1:0]    paddr,
	input  logic [mdm_pkg::DATA_W-1:0]    pwdata,
	output logic [mdm_pkg::DATA_W-1:0]    prdata,
	output logic                          pready
);

	localparam int IW     = $clog2(SINE_TABLE_DEPTH + 1);
	localparam int ITEM_W = mdm_pkg::SPEED_W + 1 + 2 + 1 + ANGLE_BITS + 2 * (IW + 1);
	localparam int AW     = mdm_pkg::ADDR_W;

	logic [mdm_pkg::RPM_W-1:0]  max_rpm_q;
	logic [mdm_pkg::RPM_W-1:0]  rotate_min_q;
	logic [mdm_pkg::RPM_W-1:0]  rotate_max_q;
	logic [mdm_pkg::GAIN_W-1:0] rotate_gain_q;
	logic [mdm_pkg::MAP_W-1:0]  channel_map_q;
	logic [mdm_pkg::INV_W-1:0]  invert_mask_q;

	logic                       cfg_wr;
	mdm_pkg::reg_idx_t          cfg_idx;

	logic                       push_valid;
	logic                       push_ready;
	logic [ITEM_W-1:0]          push_item;
	logic                       pop_valid;
	logic                       pop_ready;
	logic [ITEM_W-1:0]          pop_item;

	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign cfg_idx = mdm_pkg::reg_idx_t'(paddr[AW-1:2]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_rpm_q     <= mdm_pkg::MAX_RPM_RST;
			rotate_min_q  <= mdm_pkg::ROTATE_MIN_RST;
			rotate_max_q  <= mdm_pkg::ROTATE_MAX_RST;
			rotate_gain_q <= mdm_pkg::ROTATE_GAIN_RST;
			channel_map_q <= mdm_pkg::CHANNEL_MAP_RST;
			invert_mask_q <= mdm_pkg::INVERT_MASK_RST;
		end else if (cfg_wr) begin
			case (cfg_idx)
				mdm_pkg::REG_MAX_RPM:     max_rpm_q     <= pwdata[mdm_pkg::RPM_W-1:0];
				mdm_pkg::REG_ROTATE_MIN:  rotate_min_q  <= pwdata[mdm_pkg::RPM_W-1:0];
				mdm_pkg::REG_ROTATE_MAX:  rotate_max_q  <= pwdata[mdm_pkg::RPM_W-1:0];
				mdm_pkg::REG_ROTATE_GAIN: rotate_gain_q <= pwdata[mdm_pkg::GAIN_W-1:0];
				mdm_pkg::REG_CHANNEL_MAP: channel_map_q <= pwdata[mdm_pkg::MAP_W-1:0];
				mdm_pkg::REG_INVERT_MASK: invert_mask_q <= pwdata[mdm_pkg::INV_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (cfg_idx)
			mdm_pkg::REG_MAX_RPM:     prdata = mdm_pkg::DATA_W'(max_rpm_q);
			mdm_pkg::REG_ROTATE_MIN:  prdata = mdm_pkg::DATA_W'(rotate_min_q);
			mdm_pkg::REG_ROTATE_MAX:  prdata = mdm_pkg::DATA_W'(rotate_max_q);
			mdm_pkg::REG_ROTATE_GAIN: prdata = mdm_pkg::DATA_W'(rotate_gain_q);
			mdm_pkg::REG_CHANNEL_MAP: prdata = mdm_pkg::DATA_W'(channel_map_q);
			mdm_pkg::REG_INVERT_MASK: prdata = mdm_pkg::DATA_W'(invert_mask_q);
			default:                  prdata = '0;
		endcase
	end

	mdm_front #(
		.ANGLE_BITS       (ANGLE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.ITEM_W           (ITEM_W)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.max_rpm    (max_rpm_q),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item)
	);

	mdm_queue #(
		.W     (ITEM_W),
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	mdm_back #(
		.ANGLE_BITS       (ANGLE_BITS),
		.SINE_TABLE_DEPTH (SINE_TABLE_DEPTH),
		.GAIN_SHIFT       (GAIN_SHIFT),
		.DEADBAND_ANGLE   (DEADBAND_ANGLE),
		.ITEM_W           (ITEM_W)
	) u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.pop_valid   (pop_valid),
		.pop_ready   (pop_ready),
		.pop_item    (pop_item),
		.max_rpm     (max_rpm_q),
		.rotate_min  (rotate_min_q),
		.rotate_max  (rotate_max_q),
		.rotate_gain (rotate_gain_q),
		.channel_map (channel_map_q),
		.invert_mask (invert_mask_q),
		.wheel       (wheel)
	);

endmodule

// ----- verif/mecanum_drive_mixer_top_test.sv -----
// ----------------------------------------------------------------------------
// mecanum_drive_mixer_top_test
// Self-checking bench for the mecanum drive mixer. Sends drive requests and
// register writes, predicts every wheel result with its own model of the
// heading hold, rotate clamp and wheel mix, and compares results in order
// under random sender and receiver idling and a long receiver hold-off.
// ----------------------------------------------------------------------------
module mecanum_drive_mixer_top_test;

	localparam int CYCLE_LIMIT  = 400000;
	localparam int PIPE_LATENCY = 4;
	localparam int HOLD_CYCLES  = 300;
	localparam int TABLE_DEPTH  = 256;
	localparam int GAIN_SH      = 13;
	localparam int DEADBAND     = 364;
	localparam longint unsigned QUARTER_TURN = 16384;
	localparam logic [mdm_pkg::ANGLE_W-1:0] EIGHTH_TURN = 16'd8192;
	localparam int REG_WIDTH [6] = '{mdm_pkg::RPM_W, mdm_pkg::RPM_W, mdm_pkg::RPM_W,
		mdm_pkg::GAIN_W, mdm_pkg::MAP_W, mdm_pkg::INV_W};

	typedef struct packed {
		logic [mdm_pkg::SPEED_W-1:0] speed;
		logic [mdm_pkg::ANGLE_W-1:0] dir;
		logic [mdm_pkg::ANGLE_W-1:0] target;
		logic [mdm_pkg::ANGLE_W-1:0] meas;
		mdm_pkg::mode_req_t          req;
	} drive_cmd_t;

	typedef struct packed {
		logic [3:0][mdm_pkg::WHEEL_W-1:0] wheel;
		logic                             speed_err;
		logic [1:0]                       mode;
	} wheel_set_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel, penable, pwrite;
	logic [mdm_pkg::ADDR_W-1:0] paddr;
	logic [mdm_pkg::DATA_W-1:0] pwdata, prdata;
	logic pready;

	mdm_cmd_if   cmd_ch ();
	mdm_wheel_if wheel_ch ();

	mecanum_drive_mixer_top dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd_ch),
		.wheel   (wheel_ch),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	// model state
	logic [mdm_pkg::DATA_W-1:0] reg_shadow [6];
	mdm_pkg::turn_mode_t        heading_mode;
	longint unsigned            sine_q15_rom [TABLE_DEPTH+1];
	wheel_set_t                 pending_wheels [$];

	string wheel_name [4] = '{"front_right", "front_left", "back_right", "back_left"};

	int cmd_idle_pct;
	int wheel_stall_pct;
	bit hold_req;
	int hold_left;
	int cycle_count;
	int cmds_sent;
	int results_checked;
	int reg_writes;
	int fail_count;

	always #4 clk = ~clk;

	function automatic void build_sine_rom();
		longint unsigned x, term, sum;
		for (longint unsigned i = 0; i <= TABLE_DEPTH; i++) begin
			x = i * mdm_pkg::PI_Q30 / (2 * TABLE_DEPTH);
			term = x;
			sum = x;
			for (longint unsigned k = 1; k <= 8; k++) begin
				term = (term * x) >> 30;
				term = (term * x) >> 30;
				term = term / ((2 * k) * (2 * k + 1));
				if (k % 2 == 1)
					sum = (sum >= term) ? sum - term : 0;
				else
					sum = sum + term;
			end
			sum = (sum + 16384) >> 15;
			if (sum > 32768)
				sum = 32768;
			sine_q15_rom[i] = sum;
		end
	endfunction

	function automatic longint table_sine(logic [mdm_pkg::ANGLE_W-1:0] ang);
		longint unsigned idx;
		longint v;
		idx = ang[13:0];
		idx = (idx * TABLE_DEPTH + QUARTER_TURN / 2) >> 14;
		if (idx > TABLE_DEPTH)
			idx = TABLE_DEPTH;
		if (ang[14])
			idx = TABLE_DEPTH - idx;
		v = sine_q15_rom[idx];
		return ang[15] ? -v : v;
	endfunction

	function automatic longint mag_of(longint v);
		return (v < 0) ? -v : v;
	endfunction

	function automatic longint scale_by_speed(longint unsigned speed, longint s);
		longint unsigned mag;
		longint r;
		mag = mag_of(s);
		r = (speed * mag + 16384) >> 15;
		return (s < 0) ? -r : r;
	endfunction

	// heading error, rotate term, wheel mix and remap for one request
	function automatic wheel_set_t mix_wheels(drive_cmd_t c);
		wheel_set_t res;
		logic [mdm_pkg::ANGLE_W-1:0] d, rel;
		longint err, rot, v1, v2, big, room, w, lim;
		longint raw [4];
		longint unsigned aerr, prod, m;
		logic [1:0] src;
		case (c.req)
			mdm_pkg::REQ_SHORTEST: heading_mode = mdm_pkg::MODE_SHORTEST;
			mdm_pkg::REQ_CCW:      heading_mode = mdm_pkg::MODE_CCW;
			mdm_pkg::REQ_CW:       heading_mode = mdm_pkg::MODE_CW;
			default: ;
		endcase
		res = '0;
		res.mode = heading_mode;
		lim = reg_shadow[mdm_pkg::REG_MAX_RPM];
		if (c.speed > lim) begin
			res.speed_err = 1'b1;
			return res;
		end
		d = c.target - c.meas;
		err = d;
		if (heading_mode == mdm_pkg::MODE_CW && d != 0)
			err = err - 65536;
		else if (heading_mode == mdm_pkg::MODE_SHORTEST && d > 16'd32768)
			err = err - 65536;
		aerr = mag_of(err);
		if (aerr < QUARTER_TURN)
			heading_mode = mdm_pkg::MODE_SHORTEST;
		prod = aerr * reg_shadow[mdm_pkg::REG_ROTATE_GAIN];
		if (aerr < DEADBAND || prod == 0) begin
			rot = 0;
		end else begin
			m = prod >> GAIN_SH;
			if (m < reg_shadow[mdm_pkg::REG_ROTATE_MIN])
				m = reg_shadow[mdm_pkg::REG_ROTATE_MIN];
			else if (m > reg_shadow[mdm_pkg::REG_ROTATE_MAX])
				m = reg_shadow[mdm_pkg::REG_ROTATE_MAX];
			rot = m;
			if (err < 0)
				rot = -rot;
		end
		rel = c.dir - c.meas;
		v1 = scale_by_speed(c.speed, table_sine(rel - EIGHTH_TURN));
		v2 = scale_by_speed(c.speed, table_sine(rel + EIGHTH_TURN));
		// the largest wheel is max(|v1|,|v2|) + |rot|
		big = (mag_of(v1) > mag_of(v2)) ? mag_of(v1) : mag_of(v2);
		if (big + mag_of(rot) > lim) begin
			room = lim - big;
			rot = (rot < 0) ? -room : ((rot > 0) ? room : 0);
		end
		raw[0] = v1 + rot;
		raw[1] = v2 - rot;
		raw[2] = v2 + rot;
		raw[3] = v1 - rot;
		for (int j = 0; j < 4; j++) begin
			src = reg_shadow[mdm_pkg::REG_CHANNEL_MAP][2*j +: 2];
			w = raw[src];
			if (reg_shadow[mdm_pkg::REG_INVERT_MASK][j])
				w = -w;
			res.wheel[j] = w[mdm_pkg::WHEEL_W-1:0];
		end
		res.mode = heading_mode;
		return res;
	endfunction

	task automatic send_cmd(drive_cmd_t c);
		@(negedge clk);
		while ($urandom_range(99) < cmd_idle_pct) begin
			cmd_ch.valid <= 1'b0;
			@(negedge clk);
		end
		cmd_ch.valid            <= 1'b1;
		cmd_ch.drive_speed      <= c.speed;
		cmd_ch.drive_direction  <= c.dir;
		cmd_ch.target_heading   <= c.target;
		cmd_ch.measured_heading <= c.meas;
		cmd_ch.mode_request     <= c.req;
		@(posedge clk);
		while (!cmd_ch.ready)
			@(posedge clk);
		pending_wheels.push_back(mix_wheels(c));
		cmds_sent++;
	endtask

	task automatic wait_for_wheels();
		@(negedge clk);
		cmd_ch.valid <= 1'b0;
		while (pending_wheels.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(mdm_pkg::reg_idx_t idx, logic [mdm_pkg::DATA_W-1:0] value);
		logic [mdm_pkg::DATA_W-1:0] kept;
		kept = value & mdm_pkg::DATA_W'((64'd1 << REG_WIDTH[idx]) - 64'd1);
		reg_shadow[idx] = kept;
		reg_writes++;
		@(negedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		// read back
		@(negedge clk);
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(negedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		if (prdata !== kept) begin
			$display("%0t: register %s expected %h actual %h", $time, idx.name(), kept,
				prdata);
			fail_count++;
		end
		@(negedge clk);
		psel    <= 1'b0;
		penable <= 1'b0;
	endtask

	task automatic apply_settings(int rpm, int rmin, int rmax, int gain, int map, int inv);
		wait_for_wheels();
		write_reg(mdm_pkg::REG_MAX_RPM, rpm);
		write_reg(mdm_pkg::REG_ROTATE_MIN, rmin);
		write_reg(mdm_pkg::REG_ROTATE_MAX, rmax);
		write_reg(mdm_pkg::REG_ROTATE_GAIN, gain);
		write_reg(mdm_pkg::REG_CHANNEL_MAP, map);
		write_reg(mdm_pkg::REG_INVERT_MASK, inv);
	endtask

	function automatic logic [mdm_pkg::SPEED_W-1:0] pick_speed();
		if ($urandom_range(99) < 85)
			return mdm_pkg::SPEED_W'($urandom_range(int'(reg_shadow[mdm_pkg::REG_MAX_RPM]), 0));
		return mdm_pkg::SPEED_W'($urandom_range(16383, 0));
	endfunction

	// heading offsets clustered on the deadband, quarter and half turn edges
	function automatic logic [mdm_pkg::ANGLE_W-1:0] pick_offset();
		logic [mdm_pkg::ANGLE_W-1:0] off;
		case ($urandom_range(5))
			0: off = mdm_pkg::ANGLE_W'($urandom_range(1200) - 600);
			1: off = mdm_pkg::ANGLE_W'(DEADBAND - 3 + $urandom_range(6));
			2: off = mdm_pkg::ANGLE_W'(16384 - 3 + $urandom_range(6));
			3: off = mdm_pkg::ANGLE_W'(32768 - 3 + $urandom_range(6));
			default: off = mdm_pkg::ANGLE_W'($urandom);
		endcase
		if ($urandom_range(1))
			off = -off;
		return off;
	endfunction

	task automatic send_noise();
		drive_cmd_t c;
		c.speed  = pick_speed();
		c.dir    = mdm_pkg::ANGLE_W'($urandom);
		c.meas   = mdm_pkg::ANGLE_W'($urandom);
		c.target = c.meas + pick_offset();
		c.req    = mdm_pkg::mode_req_t'($urandom_range(3));
		send_cmd(c);
	endtask

	// a turn request followed by kept-mode updates with the error closing in
	task automatic send_heading_run();
		drive_cmd_t c;
		int n;
		int gap;
		c.speed = pick_speed();
		c.dir   = mdm_pkg::ANGLE_W'($urandom);
		c.meas  = mdm_pkg::ANGLE_W'($urandom);
		c.req   = mdm_pkg::mode_req_t'($urandom_range(3, 1));
		gap = int'($signed(pick_offset()));
		n = $urandom_range(8, 2);
		for (int i = 0; i < n; i++) begin
			c.target = c.meas + mdm_pkg::ANGLE_W'(gap);
			send_cmd(c);
			c.req = mdm_pkg::REQ_KEEP;
			gap = gap - gap / int'($urandom_range(4, 2));
			c.meas = c.meas + mdm_pkg::ANGLE_W'($urandom_range(400)) - 16'd200;
			c.target = c.meas + mdm_pkg::ANGLE_W'(gap);
			c.dir = c.dir + mdm_pkg::ANGLE_W'($urandom_range(2000)) - 16'd1000;
			if ($urandom_range(3) == 0)
				c.speed = pick_speed();
		end
	endtask

	task automatic send_random_mix(int count);
		int target_count;
		target_count = cmds_sent + count;
		while (cmds_sent < target_count) begin
			if ($urandom_range(99) < 75)
				send_heading_run();
			else
				send_noise();
		end
	endtask

	task automatic test_directed();
		send_cmd('{14'd0, 16'h0000, 16'h0000, 16'h0000, mdm_pkg::REQ_SHORTEST});
		send_cmd('{14'd4000, 16'h0000, 16'h0000, 16'h0000, mdm_pkg::REQ_KEEP});
		send_cmd('{14'd4001, 16'h0000, 16'h0000, 16'h0000, mdm_pkg::REQ_CCW});
		send_cmd('{14'd16383, 16'hFFFF, 16'hFFFF, 16'h0000, mdm_pkg::REQ_KEEP});
		send_cmd('{14'd1000, 16'h4000, 16'd100, 16'h0000, mdm_pkg::REQ_KEEP});
		send_cmd('{14'd1000, 16'h0000, 16'd1000, 16'd1000, mdm_pkg::REQ_CW});
		send_cmd('{14'd3000, 16'd8192, 16'd1000, 16'h0000, mdm_pkg::REQ_CW});
		send_cmd('{14'd3000, 16'h8000, 16'h0000, 16'd20000, mdm_pkg::REQ_KEEP});
		send_cmd('{14'd2000, 16'h7FFF, 16'h0000, 16'd10000, mdm_pkg::REQ_KEEP});
		send_cmd('{14'd2000, 16'h8000, 16'h8000, 16'h0000, mdm_pkg::REQ_SHORTEST});
		send_cmd('{14'd2000, 16'h0000, 16'h8001, 16'h0000, mdm_pkg::REQ_KEEP});
		send_cmd('{14'd1500, 16'hC000, 16'd363, 16'h0000, mdm_pkg::REQ_KEEP});
		send_cmd('{14'd1500, 16'h2000, 16'd364, 16'h0000, mdm_pkg::REQ_KEEP});
		send_cmd('{14'd1500, 16'h6000, 16'hFE94, 16'h0000, mdm_pkg::REQ_KEEP});
		send_cmd('{14'd500, 16'h0000, 16'h1234, 16'h1234, mdm_pkg::REQ_CCW});
		send_cmd('{14'd3999, 16'h7FFF, 16'h7FFF, 16'h8000, mdm_pkg::REQ_SHORTEST});
		send_cmd('{14'd4000, 16'd8192, 16'd12000, 16'h0000, mdm_pkg::REQ_CCW});
		send_cmd('{14'd4000, 16'hE000, 16'hC000, 16'h0000, mdm_pkg::REQ_CCW});
		send_cmd('{14'd4000, 16'h0000, 16'h4000, 16'h0000, mdm_pkg::REQ_KEEP});
		send_cmd('{14'd4000, 16'h0000, 16'h3FFF, 16'h0000, mdm_pkg::REQ_KEEP});
		send_cmd('{14'd2500, 16'h1000, 16'h8000, 16'h7FFF, mdm_pkg::REQ_CW});
		send_cmd('{14'd2730, 16'h5555, 16'hAAAA, 16'h5555, mdm_pkg::REQ_SHORTEST});
		send_cmd('{14'd1365, 16'hAAAA, 16'h5555, 16'hAAAA, mdm_pkg::REQ_KEEP});
	endtask

	task automatic test_register_settings();
		// wide limits, full gain, reversed channels, all inverted
		apply_settings(16383, 1, 16383, 65535, 8'h1B, 4'hF);
		send_cmd('{14'd16383, 16'd8192, 16'h8000, 16'h0000, mdm_pkg::REQ_SHORTEST});
		send_random_mix(50);
		// minimum above maximum, zero gain, one source everywhere
		apply_settings(1, 16383, 1, 0, 8'h00, 4'h5);
		send_cmd('{14'd1, 16'h0000, 16'h4000, 16'h0000, mdm_pkg::REQ_SHORTEST});
		send_random_mix(50);
		apply_settings(16383, 500, 200, 3000, 8'hFF, 4'hA);
		send_cmd('{14'd8000, 16'h3000, 16'd2000, 16'h0000, mdm_pkg::REQ_KEEP});
		send_random_mix(50);
		apply_settings(8000, 1, 16383, 65535, 8'h4E, 4'h3);
		send_random_mix(50);
		for (int i = 0; i < 2; i++) begin
			apply_settings($urandom_range(16383, 1), $urandom_range(16383, 1),
				$urandom_range(16383, 1), $urandom_range(65535), $urandom_range(255),
				$urandom_range(15));
			send_random_mix(50);
		end
		apply_settings(mdm_pkg::MAX_RPM_RST, mdm_pkg::ROTATE_MIN_RST,
			mdm_pkg::ROTATE_MAX_RST, mdm_pkg::ROTATE_GAIN_RST,
			mdm_pkg::CHANNEL_MAP_RST, mdm_pkg::INVERT_MASK_RST);
		send_random_mix(30);
	endtask

	task automatic test_idle_mix();
		cmd_idle_pct = 0;
		wheel_stall_pct = 0;
		send_random_mix(310);
		cmd_idle_pct = 79;
		send_random_mix(310);
		cmd_idle_pct = 0;
		wheel_stall_pct = 79;
		send_random_mix(310);
		cmd_idle_pct = 22;
		wheel_stall_pct = 22;
		send_random_mix(310);
		cmd_idle_pct = 0;
		wheel_stall_pct = 0;
	endtask

	task automatic test_backpressure();
		wait_for_wheels();
		hold_req = 1'b1;
		send_random_mix(60);
		wait_for_wheels();
	endtask

	task automatic check_wheels();
		wheel_set_t want, got;
		got.wheel[0]  = wheel_ch.wheel_front_right;
		got.wheel[1]  = wheel_ch.wheel_front_left;
		got.wheel[2]  = wheel_ch.wheel_back_right;
		got.wheel[3]  = wheel_ch.wheel_back_left;
		got.speed_err = wheel_ch.speed_error;
		got.mode      = wheel_ch.active_mode;
		if (pending_wheels.size() == 0) begin
			$display("%0t: wheel result with none expected, actual %h", $time, got);
			fail_count++;
			return;
		end
		want = pending_wheels.pop_front();
		results_checked++;
		for (int j = 0; j < 4; j++) begin
			if (got.wheel[j] !== want.wheel[j]) begin
				$display("%0t: %s expected %0d actual %0d", $time, wheel_name[j],
					$signed(want.wheel[j]), $signed(got.wheel[j]));
				fail_count++;
			end
		end
		if (got.speed_err !== want.speed_err) begin
			$display("%0t: speed_error expected %b actual %b", $time, want.speed_err,
				got.speed_err);
			fail_count++;
		end
		if (got.mode !== want.mode) begin
			$display("%0t: active_mode expected %0d actual %0d", $time, want.mode,
				got.mode);
			fail_count++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && wheel_ch.valid && wheel_ch.ready)
			check_wheels();
	end

	// receiver ready, with a long hold-off on request
	always @(negedge clk) begin
		if (hold_req) begin
			hold_req = 1'b0;
			hold_left = HOLD_CYCLES;
		end
		if (hold_left > 0) begin
			hold_left--;
			wheel_ch.ready <= 1'b0;
		end else begin
			wheel_ch.ready <= ($urandom_range(99) >= wheel_stall_pct);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("mecanum_drive_mixer_top verification failed");
			$finish;
		end
	end

	initial begin
		arst_n                  = 1'b0;
		cmd_ch.valid            = 1'b0;
		cmd_ch.drive_speed      = '0;
		cmd_ch.drive_direction  = '0;
		cmd_ch.target_heading   = '0;
		cmd_ch.measured_heading = '0;
		cmd_ch.mode_request     = mdm_pkg::REQ_KEEP;
		wheel_ch.ready          = 1'b0;
		psel                    = 1'b0;
		penable                 = 1'b0;
		pwrite                  = 1'b0;
		paddr                   = '0;
		pwdata                  = '0;
		cmd_idle_pct            = 0;
		wheel_stall_pct         = 0;
		hold_req                = 1'b0;
		hold_left               = 0;
		reg_shadow[mdm_pkg::REG_MAX_RPM]     = mdm_pkg::MAX_RPM_RST;
		reg_shadow[mdm_pkg::REG_ROTATE_MIN]  = mdm_pkg::ROTATE_MIN_RST;
		reg_shadow[mdm_pkg::REG_ROTATE_MAX]  = mdm_pkg::ROTATE_MAX_RST;
		reg_shadow[mdm_pkg::REG_ROTATE_GAIN] = mdm_pkg::ROTATE_GAIN_RST;
		reg_shadow[mdm_pkg::REG_CHANNEL_MAP] = mdm_pkg::CHANNEL_MAP_RST;
		reg_shadow[mdm_pkg::REG_INVERT_MASK] = mdm_pkg::INVERT_MASK_RST;
		heading_mode = mdm_pkg::MODE_SHORTEST;
		build_sine_rom();
		repeat (7)
			@(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		test_directed();
		test_register_settings();
		test_idle_mix();
		test_backpressure();

		wait_for_wheels();
		repeat (PIPE_LATENCY + 6)
			@(posedge clk);
		$display("%0d drive requests, %0d wheel results checked, %0d register writes",
			cmds_sent, results_checked, reg_writes);
		$display("covered turn modes, deadband, clamps, trim, remap, idling and hold-off");
		if (fail_count == 0)
			$display("mecanum_drive_mixer_top verification clean");
		else
			$display("mecanum_drive_mixer_top verification failed");
		$finish;
	end

endmodule
